// ----- sv/negacyclic_poly_ring_alu_defines.svh -----
// Assertion macros used by the checker of the polynomial ring unit.
// No dependencies; included by the checker file.
`ifndef NEGACYCLIC_POLY_RING_ALU_DEFINES_SVH
`define NEGACYCLIC_POLY_RING_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NPRA_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NPRA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/npra_pkg.sv -----
// Shared constants, types and state encoding of the polynomial ring unit.
// No dependencies; used by the reducer, the top level and the checker through scoped names.
package npra_pkg;

    // ring and modulus
    localparam int RING_DEGREE = 64;
    localparam int MODULUS     = 3329;
    localparam int COEF_W      = $clog2(MODULUS);
    localparam int IDX_W       = $clog2(RING_DEGREE);
    localparam int LIDX_W      = $clog2(RING_DEGREE + 1);

    // port widths
    localparam int IN_W   = 32;
    localparam int RES_W  = 12;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int REG_IDX_W = ADDR_W - 2;

    // signed sum of N products, each below Q*Q
    localparam int ACC_W   = 2 * COEF_W + $clog2(RING_DEGREE) + 1;

    // digit-serial reducer sizing
    localparam int DIGIT_W = 4;
    localparam int RED_RAW = (ACC_W > IN_W) ? ACC_W : IN_W;
    localparam int RED_W   = ((RED_RAW + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int DIGITS  = RED_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(DIGITS);
    // 2^RED_W mod Q, taken off the unsigned remainder of a negative word
    localparam logic [COEF_W-1:0] RED_CORR = COEF_W'((64'd1 << RED_W) % 64'(MODULUS));

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    // register word index
    localparam logic [REG_IDX_W-1:0] REG_OP_MODE = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RED,
        S_EW_RD,
        S_EW_OUT,
        S_MUL,
        S_MUL_WAIT,
        S_MUL_OUT
    } t_state;

    // reducer request and response
    typedef struct packed {
        logic             start;
        logic [RED_W-1:0] value;
    } t_red_req;

    typedef struct packed {
        logic              done;
        logic [COEF_W-1:0] result;
    } t_red_rsp;

endpackage

// ----- sv/npra_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module npra_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/npra_reduce.sv -----
// Digit-serial reduction of a two's complement word modulo Q.
// Depends on npra_pkg. Four bits per cycle from the top, then a sign fix.
module npra_reduce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  npra_pkg::t_red_req i_req,
    output npra_pkg::t_red_rsp o_rsp
);

    localparam int TW = npra_pkg::COEF_W + npra_pkg::DIGIT_W;
    localparam logic [TW-1:0] Q_T = TW'(npra_pkg::MODULUS);
    localparam logic [npra_pkg::COEF_W:0] Q_W1 = (npra_pkg::COEF_W + 1)'(npra_pkg::MODULUS);

    logic                          r_busy;
    logic                          r_fix;
    logic                          r_done;
    logic [npra_pkg::DCNT_W-1:0]   r_cnt;
    logic [npra_pkg::RED_W-1:0]    r_shift;
    logic                          r_neg;
    logic [npra_pkg::COEF_W-1:0]   r_rem;
    logic [npra_pkg::COEF_W-1:0]   r_res;
    logic [npra_pkg::COEF_W:0]     w_fix;

    // rem*16 + digit, brought back below Q by binary compare-subtract
    function automatic logic [npra_pkg::COEF_W-1:0] digit_step(
        input logic [npra_pkg::COEF_W-1:0]  rem,
        input logic [npra_pkg::DIGIT_W-1:0] dig
    );
        logic [TW-1:0] t;
        t = {rem, dig};
        for (int s = npra_pkg::DIGIT_W - 1; s >= 0; s--) begin
            if (t >= (Q_T << s)) begin
                t = t - (Q_T << s);
            end
        end
        return t[npra_pkg::COEF_W-1:0];
    endfunction

    // negative word: subtract 2^RED_W mod Q
    always_comb begin
        if (!r_neg || (r_rem >= npra_pkg::RED_CORR)) begin
            w_fix = {1'b0, r_rem} - {1'b0, (r_neg ? npra_pkg::RED_CORR : '0)};
        end else begin
            w_fix = {1'b0, r_rem} + Q_W1 - {1'b0, npra_pkg::RED_CORR};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_fix  <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt == npra_pkg::DCNT_W'(npra_pkg::DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt   <= '0;
            r_shift <= i_req.value;
            r_neg   <= i_req.value[npra_pkg::RED_W-1];
            r_rem   <= '0;
        end else if (r_busy) begin
            r_cnt   <= r_cnt + 1'b1;
            r_shift <= r_shift << npra_pkg::DIGIT_W;
            r_rem   <= digit_step(r_rem,
                                  r_shift[npra_pkg::RED_W-1 -: npra_pkg::DIGIT_W]);
        end
        if (r_fix) begin
            r_res <= w_fix[npra_pkg::COEF_W-1:0];
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

// ----- sv/negacyclic_poly_ring_alu.sv -----
// Polynomial ring unit over Z_Q[x]/(x^N+1): add, subtract, negacyclic multiply.
// Depends on npra_pkg, npra_ram and npra_reduce.
//
// Input channel (i_in_valid / o_in_stall) carries coefficient pairs, lowest
// index first; i_load_last marks the final pair and starts the operation.
// Each pair is reduced mod Q on entry by two digit-serial reducers; the input
// stays stalled through the 8 digit steps, a sign fix and the store write.
// Operands sit in two RAMs of N entries with a registered read.
// Add and subtract read each coefficient pair and load its result into the
// output register before the next read. Multiply computes each output
// coefficient as N multiply-accumulates through one shared multiplier,
// then reduces the sum in reducer A before the next coefficient starts.
// Results leave on o_out_valid / i_out_stall through one output register;
// a stall holds the register, and the sequencer waits with its next result
// until it drains; the next pair is taken once the last result is registered.
// Reset (synchronous, active low) sets op_mode to multiply and the load
// index to zero; operand RAM contents are undefined until written.
// op_mode is written through the APB port at byte address 0.
module negacyclic_poly_ring_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [npra_pkg::IN_W-1:0]    i_a_coeff,
    input  logic signed [npra_pkg::IN_W-1:0]    i_b_coeff,
    input  logic                                i_load_last,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [npra_pkg::RES_W-1:0]          o_result_coeff,
    output logic                                o_result_last,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [npra_pkg::ADDR_W-1:0]         paddr,
    input  logic [npra_pkg::DATA_W-1:0]         pwdata,
    output logic [npra_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int CW = npra_pkg::COEF_W;
    localparam int IW = npra_pkg::IDX_W;
    localparam logic [CW:0] Q_W1 = (CW + 1)'(npra_pkg::MODULUS);
    localparam logic [IW-1:0] IDX_LAST = IW'(npra_pkg::RING_DEGREE - 1);

    npra_pkg::t_state r_state, n_state;

    logic [npra_pkg::OP_W-1:0]   r_op_mode;
    logic [npra_pkg::LIDX_W-1:0] r_load_idx, n_load_idx;
    logic [IW-1:0]               r_k, n_k;
    logic [IW-1:0]               r_i, n_i;
    logic                        r_last;

    // multiply pipeline
    logic                         r_s1_vld, r_s1_neg, r_s1_end;
    logic                         r_s2_vld, r_s2_neg, r_s2_end;
    logic [2*CW-1:0]              r_prod;
    logic signed [npra_pkg::ACC_W-1:0] r_acc;
    logic signed [npra_pkg::ACC_W-1:0] w_prod_ext, w_sum;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_coeff, n_out_coeff;
    logic          r_out_last, n_out_last;

    logic w_in_accept, w_out_free, w_out_load, w_is_mul, w_issue;
    logic w_k_last, w_i_last, w_we, w_cfg_wr;

    logic [IW-1:0] w_a_raddr, w_b_raddr, w_j;
    logic [IW:0]   w_j_wide;
    logic [CW-1:0] w_a_rd, w_b_rd, w_ew_res, w_out_data;
    logic [CW:0]   w_add_raw, w_sub_raw;

    npra_pkg::t_red_req w_req_a, w_req_b;
    npra_pkg::t_red_rsp w_rsp_a, w_rsp_b;

    // operand stores
    npra_ram #(.WIDTH(CW), .DEPTH(npra_pkg::RING_DEGREE)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_load_idx[IW-1:0]),
        .i_wdata (w_rsp_a.result),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rd)
    );

    npra_ram #(.WIDTH(CW), .DEPTH(npra_pkg::RING_DEGREE)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_load_idx[IW-1:0]),
        .i_wdata (w_rsp_b.result),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rd)
    );

    // reducers: A also reduces the multiply sums
    npra_reduce u_red_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_a),
        .o_rsp   (w_rsp_a)
    );

    npra_reduce u_red_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req_b),
        .o_rsp   (w_rsp_b)
    );

    // handshakes
    assign o_in_stall  = (r_state != npra_pkg::S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_k_last = (r_k == IDX_LAST);
    assign w_i_last = (r_i == IDX_LAST);

    // mode decode; the spare code multiplies
    always_comb begin
        case (r_op_mode)
            npra_pkg::OP_ADD: w_is_mul = 1'b0;
            npra_pkg::OP_SUB: w_is_mul = 1'b0;
            default:          w_is_mul = 1'b1;
        endcase
    end

    // coefficient-wise add and subtract
    always_comb begin
        w_add_raw = {1'b0, w_a_rd} + {1'b0, w_b_rd};
        if (w_add_raw >= Q_W1) begin
            w_add_raw = w_add_raw - Q_W1;
        end
        if (w_a_rd >= w_b_rd) begin
            w_sub_raw = {1'b0, w_a_rd} - {1'b0, w_b_rd};
        end else begin
            w_sub_raw = {1'b0, w_a_rd} + Q_W1 - {1'b0, w_b_rd};
        end
        case (r_op_mode)
            npra_pkg::OP_SUB: w_ew_res = w_sub_raw[CW-1:0];
            default:          w_ew_res = w_add_raw[CW-1:0];
        endcase
    end

    // partner index j = (k - i) mod N
    assign w_j_wide = {1'b0, r_k} - {1'b0, r_i}
                      + ((r_i > r_k) ? (IW + 1)'(npra_pkg::RING_DEGREE) : '0);
    assign w_j      = w_j_wide[IW-1:0];

    // RAM read addresses
    assign w_a_raddr = (r_state == npra_pkg::S_MUL) ? r_i : r_k;
    assign w_b_raddr = (r_state == npra_pkg::S_MUL) ? w_j : r_k;

    // accumulate: wrapped products are subtracted
    assign w_prod_ext = $signed(npra_pkg::ACC_W'(r_prod));
    assign w_sum      = r_s2_neg ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);

    // reducer requests
    assign w_req_a.start = w_in_accept || (r_s2_vld && r_s2_end);
    assign w_req_a.value = w_in_accept ? npra_pkg::RED_W'(i_a_coeff)
                                       : npra_pkg::RED_W'(w_sum);
    assign w_req_b.start = w_in_accept;
    assign w_req_b.value = npra_pkg::RED_W'(i_b_coeff);

    // store write once the reduced pair is ready
    assign w_we = (r_state == npra_pkg::S_LOAD_RED) && w_rsp_a.done
                  && (r_load_idx < npra_pkg::LIDX_W'(npra_pkg::RING_DEGREE));

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_load_idx = r_load_idx;
        n_k        = r_k;
        n_i        = r_i;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        w_out_data = w_ew_res;
        case (r_state)
            npra_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_state = npra_pkg::S_LOAD_RED;
                end
            end
            npra_pkg::S_LOAD_RED: begin
                if (w_rsp_a.done) begin
                    if (w_we) begin
                        n_load_idx = r_load_idx + 1'b1;
                    end
                    if (r_last) begin
                        n_load_idx = '0;
                        n_k        = '0;
                        n_i        = '0;
                        n_state    = w_is_mul ? npra_pkg::S_MUL : npra_pkg::S_EW_RD;
                    end else begin
                        n_state = npra_pkg::S_IDLE;
                    end
                end
            end
            npra_pkg::S_EW_RD: begin
                n_state = npra_pkg::S_EW_OUT;
            end
            npra_pkg::S_EW_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (w_k_last) begin
                        n_state = npra_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = npra_pkg::S_EW_RD;
                    end
                end
            end
            npra_pkg::S_MUL: begin
                w_issue = 1'b1;
                if (w_i_last) begin
                    n_i     = '0;
                    n_state = npra_pkg::S_MUL_WAIT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            npra_pkg::S_MUL_WAIT: begin
                if (w_rsp_a.done) begin
                    n_state = npra_pkg::S_MUL_OUT;
                end
            end
            npra_pkg::S_MUL_OUT: begin
                w_out_data = w_rsp_a.result;
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (w_k_last) begin
                        n_state = npra_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = npra_pkg::S_MUL;
                    end
                end
            end
            default: begin
                n_state = npra_pkg::S_IDLE;
            end
        endcase
    end

    // output register next value
    always_comb begin
        n_out_coeff = r_out_coeff;
        n_out_last  = r_out_last;
        if (w_out_load) begin
            n_out_valid = 1'b1;
            n_out_coeff = w_out_data;
            n_out_last  = w_k_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // configuration write
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npra_pkg::S_IDLE;
            r_op_mode   <= npra_pkg::OP_MUL;
            r_load_idx  <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_idx  <= n_load_idx;
            r_k         <= n_k;
            r_i         <= n_i;
            r_s1_vld    <= w_issue;
            r_s2_vld    <= r_s1_vld;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && (paddr[npra_pkg::ADDR_W-1:2] == npra_pkg::REG_OP_MODE)) begin
                r_op_mode <= pwdata[npra_pkg::OP_W-1:0];
            end
            if (r_s2_vld) begin
                r_acc <= r_s2_end ? '0 : w_sum;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_last <= i_load_last;
        end
        r_s1_neg    <= (r_i > r_k);
        r_s1_end    <= w_i_last;
        r_s2_neg    <= r_s1_neg;
        r_s2_end    <= r_s1_end;
        r_prod      <= (2 * CW)'(w_a_rd) * (2 * CW)'(w_b_rd);
        r_out_coeff <= n_out_coeff;
        r_out_last  <= n_out_last;
    end

    // ports
    assign o_out_valid    = r_out_valid;
    assign o_result_coeff = npra_pkg::RES_W'(r_out_coeff);
    assign o_result_last  = r_out_last;
    assign pready         = 1'b1;
    assign prdata = (paddr[npra_pkg::ADDR_W-1:2] == npra_pkg::REG_OP_MODE)
                    ? npra_pkg::DATA_W'(r_op_mode) : '0;

endmodule

// ----- sv/npra_checker.sv -----
// Port-level checks of the polynomial ring unit, bound to the top level.
// Depends on npra_pkg and negacyclic_poly_ring_alu_defines.svh.
`include "negacyclic_poly_ring_alu_defines.svh"

module npra_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [npra_pkg::RES_W-1:0]  o_result_coeff,
    input logic                        o_result_last
);

    logic [npra_pkg::IDX_W-1:0] r_cnt;

    // results accepted since the last marked one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_cnt <= o_result_last ? '0 : r_cnt + 1'b1;
        end
    end

    // a stalled result holds
    `NPRA_CHECK_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_result_coeff) && $stable(o_result_last),
        "stalled result changed")

    // an accepted pair keeps the input side busy while it is reduced
    `NPRA_CHECK_NEXT(a_in_busy, i_in_valid && !o_in_stall, o_in_stall,
        "input taken again right after a transaction")

    // the marked result closes a train of N results, counted modulo N
    `NPRA_CHECK_NOW(a_train_len, o_out_valid && o_result_last,
        r_cnt == npra_pkg::IDX_W'(npra_pkg::RING_DEGREE - 1),
        "result train length is not N")

endmodule

bind negacyclic_poly_ring_alu npra_checker u_npra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_coeff (o_result_coeff),
    .o_result_last  (o_result_last)
);
